### rtl/core/assert_macros.svh
// Assertion macros used by the checker file of the core.
// Needs nothing else; every macro reports through $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on the rising clock, off while reset is low.
`define MBE_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: assertion failed");

// Same-cycle implication.
`define MBE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: implication failed");

// Next-cycle implication.
`define MBE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle implication failed");

`endif

### rtl/core/mbe_pkg.sv
// Shared types and constants of the escape-time core.
// No dependencies.
`timescale 1ns / 1ps

package mbe_pkg;

  localparam int MUL_W     = 32;
  localparam int FRAC_BITS = 28;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 32;
  localparam int CNT_W     = 12;

  // Pixel array size; columns and rows wrap at these
  localparam int MAX_COLUMNS = 2048;
  localparam int MAX_ROWS    = 2048;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_REAL_LEFT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REAL_STEP  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAG_TOP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAG_STEP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ITER_LIMIT = 3'd4;

  // Reset values, Q4.28 apart from the iteration limit
  localparam logic signed [31:0] RST_REAL_LEFT  = 32'shE000_0000;
  localparam logic signed [31:0] RST_REAL_STEP  = 32'sh0006_6666;
  localparam logic signed [31:0] RST_IMAG_TOP   = 32'sh1200_0000;
  localparam logic signed [31:0] RST_IMAG_STEP  = 32'shFFF8_51EC;
  localparam logic [CNT_W-1:0]   RST_ITER_LIMIT = 12'd500;

  // |z|^2 bound of 4.0 in Q.28, held in the 37-bit magnitude sum
  localparam logic signed [36:0] ESC_BOUND = 37'sh0_4000_0000;

  localparam logic [23:0] COLOUR_INSIDE  = 24'h000000;
  localparam logic [23:0] COLOUR_OUTSIDE = 24'hFFFFFF;

  typedef struct packed {
    logic [10:0] column;
    logic [10:0] row;
  } in_item_t;

  typedef struct packed {
    logic [CNT_W-1:0] iteration_count;
    logic             in_set;
    logic [23:0]      pixel_colour;
  } out_item_t;

endpackage

### rtl/core/mbe_serial_mult.sv
// Bit-serial signed multiplier, one multiplier bit per cycle.
// Depends on mbe_pkg for the operand width.
`timescale 1ns / 1ps

module mbe_serial_mult (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [mbe_pkg::MUL_W-1:0]  a_i,
  input  logic signed [mbe_pkg::MUL_W-1:0]  b_i,
  output logic                              done_o,
  output logic signed [2*mbe_pkg::MUL_W-1:0] product_o
);
  import mbe_pkg::*;

  localparam int CntW = $clog2(MUL_W);
  localparam int AccW = MUL_W + 2;

  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic signed [MUL_W-1:0] a_q, a_d;
  logic [MUL_W-1:0]       b_q, b_d;
  logic signed [AccW-1:0] acc_q, acc_d;
  logic [MUL_W-1:0]       low_q, low_d;

  logic                   last;
  logic signed [AccW-1:0] a_ext;
  logic signed [AccW-1:0] addend;
  logic signed [AccW-1:0] sum;

  assign last  = (cnt_q == CntW'(MUL_W - 1));
  assign a_ext = AccW'(a_q);
  // top multiplier bit carries negative weight
  assign addend = b_q[0] ? (last ? -a_ext : a_ext) : '0;
  assign sum    = acc_q + addend;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    low_d  = low_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      a_d    = a_i;
      b_d    = b_i;
      acc_d  = '0;
      low_d  = '0;
    end else if (busy_q) begin
      acc_d = sum >>> 1;
      low_d = {sum[0], low_q[MUL_W-1:1]};
      b_d   = b_q >> 1;
      cnt_d = cnt_q + CntW'(1);
      if (last) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
    low_q <= low_d;
  end

  assign done_o    = done_q;
  assign product_o = {acc_q[MUL_W-1:0], low_q};

endmodule

### rtl/core/mbe_out_stage.sv
// Output register of the core: holds one result until it is transferred.
// Depends on mbe_pkg for the result type.
`timescale 1ns / 1ps

module mbe_out_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  mbe_pkg::out_item_t result_i,
  output logic               ready_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output mbe_pkg::out_item_t out_data_o
);
  import mbe_pkg::*;

  logic      valid_q, valid_d;
  out_item_t data_q;

  // room when empty or when the held result leaves this cycle
  assign ready_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

### rtl/core/mandelbrot_escape_time_core.sv
// Mandelbrot escape-time core. One pixel at a time: each escape test runs a bit-serial multiply
// of zr*zr, zi*zi and zr*zi, then evaluates the products. A new pixel is taken once the last
// one sits in the output register. Reset is asynchronous: the control and configuration
// registers return to defaults; the datapath registers are not reset.
`timescale 1ns / 1ps

module mandelbrot_escape_time_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  mbe_pkg::in_item_t                in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output mbe_pkg::out_item_t               out_data_o,
  input  logic                             cfg_we_i,
  input  logic [mbe_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [mbe_pkg::CFG_W-1:0]        cfg_data_i
);
  import mbe_pkg::*;

  localparam int PW = 2 * MUL_W;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MAP  = 4'b0010,
    S_MUL  = 4'b0100,
    S_OUT  = 4'b1000
  } state_e;

  localparam logic signed [47:0] SatHi = 48'sh0000_7FFF_FFFF;
  localparam logic signed [47:0] SatLo = 48'shFFFF_8000_0000;

  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    logic signed [31:0] r;
    if (v > SatHi) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < SatLo) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // configuration
  logic signed [31:0] real_left_q, real_step_q, imag_top_q, imag_step_q;
  logic [CNT_W-1:0]   limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      real_left_q <= RST_REAL_LEFT;
      real_step_q <= RST_REAL_STEP;
      imag_top_q  <= RST_IMAG_TOP;
      imag_step_q <= RST_IMAG_STEP;
      limit_q     <= RST_ITER_LIMIT;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_REAL_LEFT:  real_left_q <= cfg_data_i;
        CFG_REAL_STEP:  real_step_q <= cfg_data_i;
        CFG_IMAG_TOP:   imag_top_q  <= cfg_data_i;
        CFG_IMAG_STEP:  imag_step_q <= cfg_data_i;
        CFG_ITER_LIMIT: limit_q     <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic signed [31:0] cr_q, cr_d, ci_q, ci_d;
  logic signed [31:0] zr_q, zr_d, zi_q, zi_d;

  logic               accept, mul_start, out_load, out_ready;
  logic               done0, done1, done2, mul_done;
  logic signed [PW-1:0] p0, p1, p2;
  logic signed [MUL_W-1:0] a0, b0, a1, b1;
  logic [10:0]        col, row;

  // serial datapath
  logic signed [35:0] sr, si;
  logic signed [36:0] mag;
  logic               escape;
  logic signed [47:0] nr_w, ni_w, cr_w, ci_w;
  logic [CNT_W-1:0]   count_inc;
  out_item_t          result;

  assign accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);

  assign col = 11'(32'(in_data_i.column) % MAX_COLUMNS);
  assign row = 11'(32'(in_data_i.row) % MAX_ROWS);

  // Q8.56 squares floored to Q.28; cross product floored by 2^27 gives 2*zr*zi
  assign sr     = p0[PW-1:FRAC_BITS];
  assign si     = p1[PW-1:FRAC_BITS];
  assign mag    = 37'(sr) + 37'(si);
  assign escape = (mag >= ESC_BOUND);
  assign nr_w   = 48'(sr) - 48'(si) + 48'(cr_q);
  assign ni_w   = 48'($signed(p2[PW-1:FRAC_BITS-1])) + 48'(ci_q);
  assign cr_w   = p0[47:0] + 48'(real_left_q);
  assign ci_w   = p1[47:0] + 48'(imag_top_q);
  assign count_inc = count_q + CNT_W'(1);

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    cr_d      = cr_q;
    ci_d      = ci_q;
    zr_d      = zr_q;
    zi_d      = zi_q;
    mul_start = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          mul_start = 1'b1;
          state_d   = S_MAP;
        end
      end
      S_MAP: begin
        if (mul_done) begin
          cr_d    = sat32(cr_w);
          ci_d    = sat32(ci_w);
          zr_d    = '0;
          zi_d    = '0;
          count_d = '0;
          if (limit_q == '0) begin
            state_d = S_OUT;
          end else begin
            mul_start = 1'b1;
            state_d   = S_MUL;
          end
        end
      end
      S_MUL: begin
        if (mul_done) begin
          if (escape) begin
            state_d = S_OUT;
          end else begin
            zr_d    = sat32(nr_w);
            zi_d    = sat32(ni_w);
            count_d = count_inc;
            if (count_inc == limit_q) begin
              state_d = S_OUT;
            end else begin
              mul_start = 1'b1;
            end
          end
        end
      end
      S_OUT: begin
        if (out_ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // mapping uses the pixel indexes as multipliers; iterations use the new z
  assign a0 = (state_q == S_IDLE) ? real_step_q : zr_d;
  assign b0 = (state_q == S_IDLE) ? MUL_W'(col) : zr_d;
  assign a1 = (state_q == S_IDLE) ? imag_step_q : zi_d;
  assign b1 = (state_q == S_IDLE) ? MUL_W'(row) : zi_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    count_q <= count_d;
    cr_q    <= cr_d;
    ci_q    <= ci_d;
    zr_q    <= zr_d;
    zi_q    <= zi_d;
  end

  mbe_serial_mult u_mul_rr (
    .clk_i, .rst_ni,
    .start_i   (mul_start),
    .a_i       (a0),
    .b_i       (b0),
    .done_o    (done0),
    .product_o (p0)
  );

  mbe_serial_mult u_mul_ii (
    .clk_i, .rst_ni,
    .start_i   (mul_start),
    .a_i       (a1),
    .b_i       (b1),
    .done_o    (done1),
    .product_o (p1)
  );

  mbe_serial_mult u_mul_ri (
    .clk_i, .rst_ni,
    .start_i   (mul_start),
    .a_i       (zr_d),
    .b_i       (zi_d),
    .done_o    (done2),
    .product_o (p2)
  );

  // all three units share one start, so their done pulses coincide
  assign mul_done = done0 && done1 && done2;

  always_comb begin
    result.iteration_count = count_q;
    result.in_set          = (count_q == limit_q);
    result.pixel_colour    = result.in_set ? COLOUR_INSIDE : COLOUR_OUTSIDE;
  end

  mbe_out_stage u_out (
    .clk_i, .rst_ni,
    .load_i      (out_load),
    .result_i    (result),
    .ready_o     (out_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

### rtl/core/mbe_checker.sv
// Port-level checks of the escape-time core, bound to its top level.
// Depends on mbe_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mbe_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input mbe_pkg::in_item_t             in_data_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input mbe_pkg::out_item_t            out_data_o,
  input logic                          cfg_we_i,
  input logic [mbe_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input logic [mbe_pkg::CFG_W-1:0]     cfg_data_i
);
  import mbe_pkg::*;

  // colour follows the in-set flag
  `MBE_ASSERT_IMP(a_colour, clk_i, rst_ni, out_valid_o, (out_data_o.in_set ? (out_data_o.pixel_colour == COLOUR_INSIDE) : (out_data_o.pixel_colour == COLOUR_OUTSIDE)))
  // one pixel in flight: a transfer in closes the input
  `MBE_ASSERT_NXT(a_busy, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)
  // a new result comes only from a pixel at work
  `MBE_ASSERT_IMP(a_origin, clk_i, rst_ni, $rose(out_valid_o), $past(in_stall_o))
  // a stalled result holds
  `MBE_ASSERT_NXT(a_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o))

endmodule

bind mandelbrot_escape_time_core mbe_checker u_checker (.*);

### sim/testbench.sv
// Self-checking bench for mandelbrot_escape_time_core: pixels go in and escape counts come out
// under valid/stall, with random idling on both sides. Results are checked against an in-bench
// predictor of the Q4.28 iteration. Depends on mbe_pkg and the core RTL only.
`timescale 1ns / 1ps

module testbench;
  import mbe_pkg::*;

  localparam int      CYCLE_LIMIT   = 4_000_000;
  localparam int      HOLD_CYCLES   = 600;
  localparam int      SETTLE_CYCLES = 8;
  localparam int      RANDOM_BLOCKS = 12;
  localparam int      BLOCK_PIXELS  = 100;
  localparam int      PRINT_CAP     = 40;
  localparam longint  Q_ONE         = longint'(1) << FRAC_BITS;
  localparam longint  ESCAPE_Q      = 4 * Q_ONE;
  localparam longint  Q_MAX         = 64'sd2147483647;
  localparam longint  Q_MIN         = -64'sd2147483648;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_stall_o;
  in_item_t   in_data_i   = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  out_item_t  out_data_o;
  logic                 cfg_we_i   = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i  = '0;
  logic [CFG_W-1:0]     cfg_data_i = '0;

  // bench copy of the view registers
  logic signed [31:0] real_left_q = RST_REAL_LEFT;
  logic signed [31:0] real_step_q = RST_REAL_STEP;
  logic signed [31:0] imag_top_q  = RST_IMAG_TOP;
  logic signed [31:0] imag_step_q = RST_IMAG_STEP;
  logic [CNT_W-1:0]   iter_limit_q = RST_ITER_LIMIT;

  in_item_t  pending_pixels[$];
  out_item_t expected_escapes[$];
  int        pixels_queued = 0;
  int        pixels_taken  = 0;
  int        mismatch_cnt  = 0;
  int        cycle_cnt     = 0;
  int        tx_idle_pct   = 0;
  int        rx_idle_pct   = 0;
  int        hold_seq      = 0;
  int        hold_seen     = 0;
  int        hold_left     = 0;
  logic      in_taken      = 1'b0;

  mandelbrot_escape_time_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic longint clamp_q428(longint v);
    if (v > Q_MAX) return Q_MAX;
    if (v < Q_MIN) return Q_MIN;
    return v;
  endfunction

  // iterate z = z^2 + c from zero, testing |z|^2 >= 4 before each step
  function automatic out_item_t escape_time(in_item_t px);
    longint      cr, ci, zr, zi, sr, si, nr, ni;
    int unsigned steps;
    out_item_t   res;
    cr = clamp_q428(longint'(real_left_q) +
                    longint'(px.column % MAX_COLUMNS) * longint'(real_step_q));
    ci = clamp_q428(longint'(imag_top_q) +
                    longint'(px.row % MAX_ROWS) * longint'(imag_step_q));
    zr = 0;
    zi = 0;
    steps = 0;
    while (steps < iter_limit_q) begin
      sr = (zr * zr) >>> FRAC_BITS;
      si = (zi * zi) >>> FRAC_BITS;
      if (sr + si >= ESCAPE_Q) break;
      nr = clamp_q428(sr - si + cr);
      ni = clamp_q428(((zr * zi) >>> (FRAC_BITS - 1)) + ci);
      zr = nr;
      zi = ni;
      steps++;
    end
    res.iteration_count = CNT_W'(steps);
    res.in_set          = (steps == iter_limit_q);
    res.pixel_colour    = res.in_set ? COLOUR_INSIDE : COLOUR_OUTSIDE;
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatch_cnt < PRINT_CAP) $display("%0t ns mismatch: %s", $time, msg);
    mismatch_cnt++;
  endtask

  // monitor: record input transfers, check output transfers
  always @(posedge clk_i) begin
    out_item_t got, want;
    cycle_cnt <= cycle_cnt + 1;
    in_taken  <= in_valid_i && !in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      expected_escapes.push_back(escape_time(in_data_i));
      pixels_taken++;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = out_data_o;
      if (expected_escapes.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending (count %0d)",
                                  got.iteration_count));
      end else begin
        want = expected_escapes.pop_front();
        if (got.iteration_count !== want.iteration_count)
          report_mismatch($sformatf("iteration_count %0d, want %0d",
                                    got.iteration_count, want.iteration_count));
        if (got.in_set !== want.in_set)
          report_mismatch($sformatf("in_set %0b, want %0b", got.in_set, want.in_set));
        if (got.pixel_colour !== want.pixel_colour)
          report_mismatch($sformatf("pixel_colour %06h, want %06h",
                                    got.pixel_colour, want.pixel_colour));
      end
    end
  end

  // driver: payload only moves on after a transfer or from idle
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (pending_pixels.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        in_data_i  <= pending_pixels.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver: random stall, or a long hold-off when one is requested
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("[mandelbrot_escape_time_core] ERROR");
    $finish;
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      CFG_REAL_LEFT:  real_left_q  = data;
      CFG_REAL_STEP:  real_step_q  = data;
      CFG_IMAG_TOP:   imag_top_q   = data;
      CFG_IMAG_STEP:  imag_step_q  = data;
      CFG_ITER_LIMIT: iter_limit_q = data[CNT_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_view(int rl, int rs, int it, int is, int lim);
    write_reg(CFG_REAL_LEFT, rl);
    write_reg(CFG_REAL_STEP, rs);
    write_reg(CFG_IMAG_TOP, it);
    write_reg(CFG_IMAG_STEP, is);
    write_reg(CFG_ITER_LIMIT, {20'($urandom()), 12'(lim)});
  endtask

  task automatic queue_pixel(int unsigned col, int unsigned row);
    in_item_t px;
    px.column = 11'(col);
    px.row    = 11'(row);
    pending_pixels.push_back(px);
    pixels_queued++;
  endtask

  task automatic drain();
    while (pixels_taken != pixels_queued || expected_escapes.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // mostly a window near the set, now and then any view at all
  task automatic pick_view();
    if ($urandom_range(4) == 0)
      set_view($urandom(), $urandom(), $urandom(), $urandom(), $urandom_range(1, 16));
    else
      set_view(-(9 << 26) + int'($urandom_range(0, 3 << 27)),
               int'($urandom_range(0, 1 << 19)) - (1 << 18),
               int'($urandom_range(0, 3 << 28)) - (3 << 27),
               int'($urandom_range(0, 1 << 19)) - (1 << 18),
               $urandom_range(1, 16));
  endtask

  initial begin
    int blk, k;
    tx_idle_pct = 29;
    rx_idle_pct = 50;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset view: fast escapes and one point at the origin that stays inside
    queue_pixel(0, 0);
    queue_pixel(2047, 2047);
    queue_pixel(1280, 600);
    drain();

    // deepest limit
    write_reg(CFG_ITER_LIMIT, 4095);
    queue_pixel(1280, 600);
    queue_pixel(0, 0);
    drain();

    // zero limit: nothing iterates, every point is inside
    write_reg(CFG_ITER_LIMIT, 0);
    queue_pixel(0, 0);
    queue_pixel(1280, 600);
    drain();

    write_reg(CFG_ITER_LIMIT, 1);
    queue_pixel(2047, 0);
    queue_pixel(0, 2047);
    drain();

    // coordinates saturate at both ends of the range
    set_view(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 3);
    queue_pixel(2047, 2047);
    queue_pixel(0, 0);
    queue_pixel(1, 0);
    queue_pixel(0, 1);
    drain();
    set_view(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 2);
    queue_pixel(2047, 2047);
    queue_pixel(3, 5);
    drain();

    // c = -2: |z|^2 lands exactly on the bound
    set_view(-(2 << FRAC_BITS), 0, 0, 0, 8);
    queue_pixel(0, 0);
    queue_pixel(2047, 2047);
    drain();
    // writes past the last register must leave the view alone
    for (k = CFG_ITER_LIMIT + 1; k < (1 << CFG_IDX_W); k++)
      write_reg(CFG_IDX_W'(k), $urandom());
    queue_pixel(7, 7);
    drain();

    // cusp at c = 0.25, slow convergence
    set_view(1 << 26, 0, 0, 0, 40);
    queue_pixel(0, 0);
    drain();

    for (blk = 0; blk < RANDOM_BLOCKS; blk++) begin
      if (blk == RANDOM_BLOCKS / 3) begin
        tx_idle_pct = 50;
        rx_idle_pct = 29;
      end else if (blk == 2 * RANDOM_BLOCKS / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      pick_view();
      for (k = 0; k < BLOCK_PIXELS; k++)
        queue_pixel($urandom_range(0, MAX_COLUMNS - 1), $urandom_range(0, MAX_ROWS - 1));
      // long hold-off on the result side while pixels are still waiting to go in
      if (blk == 1) hold_seq++;
      drain();
    end

    drain();
    repeat (200) @(posedge clk_i);
    if (mismatch_cnt == 0 && expected_escapes.size() == 0) begin
      $display("[mandelbrot_escape_time_core] OK");
    end else begin
      $display("[mandelbrot_escape_time_core] ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/mbe_pkg.sv
rtl/core/mbe_serial_mult.sv
rtl/core/mbe_out_stage.sv
rtl/core/mandelbrot_escape_time_core.sv
rtl/core/mbe_checker.sv
sim/testbench.sv
